/* hdl/qro_pkg.sv */
// package for the quadrature rotation oscillator
// types, constants and shared arithmetic helpers; no dependencies
package qro_pkg;

  localparam int LANES = 4;
  localparam int OUT_LANES = 4;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  localparam logic signed [23:0] Q_ONE   = 24'sd4194304;
  localparam logic signed [23:0] SAT_MAX = 24'sd8388607;
  localparam logic signed [23:0] SAT_MIN = -24'sd8388608;

  localparam logic [2:0] OP_ADVANCE = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_RESYNC  = 3'd2;
  localparam logic [2:0] OP_NORM    = 3'd3;
  localparam logic [2:0] OP_FNORM   = 3'd4;

  localparam logic [1:0] REG_COS_SINGLE = 2'd0;
  localparam logic [1:0] REG_SIN_SINGLE = 2'd1;
  localparam logic [1:0] REG_COS_VECTOR = 2'd2;
  localparam logic [1:0] REG_SIN_VECTOR = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [23:0] phase_cos;
    logic signed [23:0] phase_sin;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] cos_lane0;
    logic signed [23:0] cos_lane1;
    logic signed [23:0] cos_lane2;
    logic signed [23:0] cos_lane3;
    logic signed [23:0] sin_lane0;
    logic signed [23:0] sin_lane1;
    logic signed [23:0] sin_lane2;
    logic signed [23:0] sin_lane3;
  } out_item_t;

  // lane command from the sequencer
  typedef struct packed {
    logic [2:0] op;
  } lane_cmd_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'(SAT_MAX)) return SAT_MAX;
    if (v < 64'(SAT_MIN)) return SAT_MIN;
    return v[23:0];
  endfunction

  // round half up by 2^22 then saturate, on a q6.44 sum
  function automatic logic signed [23:0] rnd22(input logic signed [49:0] v);
    logic signed [49:0] t;
    t = (v + 50'sd2097152) >>> 22;
    return sat24(64'(t));
  endfunction

endpackage

/* hdl/qro_rot.sv */
// one lane core: rotation, magnitude and normalize steps
// depends on qro_pkg
module qro_rot import qro_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lane_cmd_t          cmd,
  input  logic               rot_go,
  input  logic signed [23:0] c_in,
  input  logic signed [23:0] s_in,
  input  logic signed [23:0] rc,
  input  logic signed [23:0] rs,
  output logic signed [23:0] c_out,
  output logic signed [23:0] s_out,
  output logic               busy
);

  logic signed [47:0] p0, p1, p2, p3;
  logic               mul_v;
  logic [2:0]         mop;
  logic signed [23:0] c_hold, s_hold;

  // normalize iteration state
  logic [48:0] r2;
  logic [48:0] sq_v, sq_res, sq_bit;
  logic        sq_run;
  logic [5:0]  dcnt;
  logic        dv_run;
  logic [46:0] dnum_c, dnum_s;
  logic [24:0] dq_c, dq_s;
  logic [47:0] drem_c, drem_s;
  logic [23:0] nmag;
  logic signed [24:0] ni;

  logic [47:0] sh_c, sh_s, rs_c, rs_s;
  logic        qb_c, qb_s;

  function automatic logic signed [24:0] fn_ni(input logic [48:0] v);
    logic signed [50:0] t;
    t = (51'sd3 <<< 44) - $signed({2'b00, v});
    t = (t + 51'sd4194304) >>> 23;
    return t[24:0];
  endfunction

  // q2 holds floor(2*mag/n); rounded quotient is (q2+1)>>1
  function automatic logic signed [23:0] fin(input logic signed [23:0] x,
                                             input logic [24:0] q2);
    logic [25:0] q;
    logic signed [63:0] r;
    q = (26'(q2) + 26'd1) >> 1;
    if (q > 26'd8388608) q = 26'd8388608;
    r = x[23] ? -64'(q) : 64'(q);
    return sat24(r);
  endfunction

  assign busy = mul_v | sq_run | dv_run;

  always_comb begin
    sh_c = {drem_c[46:0], dnum_c[46]};
    sh_s = {drem_s[46:0], dnum_s[46]};
    qb_c = sh_c >= 48'(nmag);
    qb_s = sh_s >= 48'(nmag);
    rs_c = qb_c ? sh_c - 48'(nmag) : sh_c;
    rs_s = qb_s ? sh_s - 48'(nmag) : sh_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
      sq_run <= 1'b0;
      dv_run <= 1'b0;
    end else begin
      mul_v <= rot_go;
      if (rot_go) begin
        mop <= cmd.op;
        c_hold <= c_in;
        s_hold <= s_in;
        if (cmd.op == OP_NORM || cmd.op == OP_FNORM) begin
          p0 <= c_in * c_in;
          p1 <= s_in * s_in;
          p2 <= '0;
          p3 <= '0;
        end else begin
          p0 <= c_in * rc;
          p1 <= s_in * rs;
          p2 <= c_in * rs;
          p3 <= s_in * rc;
        end
      end
      if (mul_v) begin
        unique case (mop)
          OP_NORM: begin
            r2 <= 49'(p0) + 49'(p1);
            sq_v <= 49'(p0) + 49'(p1);
            sq_res <= '0;
            sq_bit <= 49'(1) << 48;
            sq_run <= 1'b1;
          end
          OP_FNORM: begin
            r2 <= 49'(p0) + 49'(p1);
            // second step reuses the multiplier inputs via fnorm stage below
            sq_run <= 1'b0;
            dv_run <= 1'b1;
            dcnt <= 6'd63;
          end
          default: begin
            c_out <= rnd22(50'(p0) - 50'(p1));
            s_out <= rnd22(50'(p2) + 50'(p3));
          end
        endcase
      end
      if (sq_run) begin
        if (sq_bit == '0) begin
          sq_run <= 1'b0;
          nmag <= sq_res[23:0];
          if (sq_res == '0) begin
            c_out <= c_hold;
            s_out <= s_hold;
          end else begin
            dv_run <= 1'b1;
            dcnt <= 6'd46;
            dnum_c <= {(c_hold[23] ? 24'(-c_hold) : c_hold), 22'd0, 1'b0};
            dnum_s <= {(s_hold[23] ? 24'(-s_hold) : s_hold), 22'd0, 1'b0};
            drem_c <= '0;
            drem_s <= '0;
            dq_c <= '0;
            dq_s <= '0;
          end
        end else if (sq_v >= sq_res + sq_bit) begin
          sq_v <= sq_v - (sq_res + sq_bit);
          sq_res <= (sq_res >> 1) + sq_bit;
          sq_bit <= sq_bit >> 2;
        end else begin
          sq_res <= sq_res >> 1;
          sq_bit <= sq_bit >> 2;
        end
      end
      if (dv_run) begin
        if (dcnt == 6'd63) begin
          // fast normalize: ni from r2, then scale both components
          ni <= fn_ni(r2);
          dcnt <= 6'd62;
        end else if (dcnt == 6'd62) begin
          dv_run <= 1'b0;
          c_out <= rnd22(50'(c_hold * ni));
          s_out <= rnd22(50'(s_hold * ni));
        end else begin
          // restoring division on doubled dividend: q2 = floor(2x*2^22/n)
          drem_c <= rs_c;
          drem_s <= rs_s;
          dq_c <= {dq_c[23:0], qb_c};
          dq_s <= {dq_s[23:0], qb_s};
          dnum_c <= dnum_c << 1;
          dnum_s <= dnum_s << 1;
          if (dcnt == 6'd0) begin
            dv_run <= 1'b0;
            c_out <= fin(c_hold, {dq_c[23:0], qb_c});
            s_out <= fin(s_hold, {dq_s[23:0], qb_s});
          end else begin
            dcnt <= dcnt - 6'd1;
          end
        end
      end
    end
  end

endmodule

/* hdl/quadrature_rotation_oscillator.sv */
// top level of the quadrature rotation oscillator
// holds step registers, lane state and sequencer; uses qro_pkg and qro_rot
//
// Four lanes hold consecutive phasor samples in signed Q2.22, one qro_rot
// core per lane. Advance runs multiply, sum and round, and lane update;
// fast normalize runs multiply, magnitude, scale factor, scaling, lane
// update and result register. Load phase and resync chain the lanes through
// the single-sample step, one lane at a time after lane 0. Exact normalize
// runs a bit-serial square root and, for a nonzero magnitude, a 47-step
// division in every lane at once. An unknown op reports the lanes
// unchanged. One item is in work at a time; the next item is accepted at
// the earliest in the cycle after the result is raised, and only while the
// result register is empty or being read.
module quadrature_rotation_oscillator import qro_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_CHN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  logic signed [23:0] csc, sss, csv, ssv;
  logic signed [23:0] lc [LANES];
  logic signed [23:0] ls [LANES];
  logic signed [23:0] rc_o [LANES];
  logic signed [23:0] rs_o [LANES];
  logic [LANES-1:0] busy, go;
  logic [2:0] op;
  logic [LANE_W-1:0] chn;
  logic started;
  lane_cmd_t cmd;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign cmd.op = (op == OP_LOAD || op == OP_RESYNC) ? OP_ADVANCE : op;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic signed [23:0] ci, si;
    assign ci = (state == S_CHN && k > 0) ? lc[(k > 0) ? k - 1 : 0] : lc[k];
    assign si = (state == S_CHN && k > 0) ? ls[(k > 0) ? k - 1 : 0] : ls[k];
    qro_rot u_rot (
      .clk(clk), .rst(rst), .cmd(cmd), .rot_go(go[k]),
      .c_in(ci), .s_in(si),
      .rc(state == S_CHN ? csc : csv), .rs(state == S_CHN ? sss : ssv),
      .c_out(rc_o[k]), .s_out(rs_o[k]), .busy(busy[k])
    );
  end

  always_comb begin
    go = '0;
    if (state == S_RUN && !started) go = '1;
    if (state == S_CHN && !started) go[chn] = 1'b1;
  end

  function automatic logic signed [23:0] pick(input logic signed [23:0] a [LANES],
                                              input int k);
    return (k < LANES) ? a[(k < LANES) ? k : 0] : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      started <= 1'b0;
      csc <= Q_ONE; sss <= '0; csv <= Q_ONE; ssv <= '0;
      for (int k = 0; k < LANES; k++) begin
        lc[k] <= Q_ONE;
        ls[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COS_SINGLE: csc <= cfg_data;
          REG_SIN_SINGLE: sss <= cfg_data;
          REG_COS_VECTOR: csv <= cfg_data;
          REG_SIN_VECTOR: ssv <= cfg_data;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= in_data.op;
            started <= 1'b0;
            out_data <= {pick(lc, 0), pick(lc, 1), pick(lc, 2), pick(lc, 3),
                         pick(ls, 0), pick(ls, 1), pick(ls, 2), pick(ls, 3)};
            if (in_data.op == OP_LOAD || in_data.op == OP_RESYNC) begin
              if (in_data.op == OP_LOAD) begin
                lc[0] <= in_data.phase_cos;
                ls[0] <= in_data.phase_sin;
              end
              if (LANES > 1) begin
                chn <= LANE_W'(1);
                state <= S_CHN;
              end else state <= S_DONE;
            end else if (in_data.op == OP_ADVANCE || in_data.op == OP_NORM ||
                         in_data.op == OP_FNORM) begin
              state <= S_RUN;
            end else state <= S_DONE;
          end
        end
        S_RUN: begin
          started <= 1'b1;
          if (started && busy == '0) begin
            for (int k = 0; k < LANES; k++) begin
              lc[k] <= rc_o[k];
              ls[k] <= rs_o[k];
            end
            state <= (op == OP_ADVANCE) ? S_IDLE : S_DONE;
            if (op == OP_ADVANCE) out_valid <= 1'b1;
          end
        end
        S_CHN: begin
          if (started && busy == '0) begin
            lc[chn] <= rc_o[chn];
            ls[chn] <= rs_o[chn];
            started <= 1'b0;
            if (32'(chn) == LANES - 1) state <= S_DONE;
            else chn <= chn + LANE_W'(1);
          end else begin
            started <= 1'b1;
          end
        end
        S_DONE: begin
          out_data <= {pick(lc, 0), pick(lc, 1), pick(lc, 2), pick(lc, 3),
                       pick(ls, 0), pick(ls, 1), pick(ls, 2), pick(ls, 3)};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sim/quadrature_rotation_oscillator_tb.sv */
// self-checking testbench for the quadrature rotation oscillator
// drives items and step registers, predicts every transaction; needs qro_pkg and the dut
`timescale 1ns / 1ps

module quadrature_rotation_oscillator_tb import qro_pkg::*; ();

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE = 120;

  class osc_scoreboard;
    longint step_c1, step_s1, step_cv, step_sv;
    longint lc[LANES], ls[LANES];
    out_item_t pending[$];
    int errors;

    function new();
      step_c1 = Q_ONE;
      step_s1 = 0;
      step_cv = Q_ONE;
      step_sv = 0;
      for (int k = 0; k < LANES; k++) begin
        lc[k] = Q_ONE;
        ls[k] = 0;
      end
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [1:0] idx, logic [23:0] v);
      longint sv;
      sv = longint'(signed'(v));
      case (idx)
        REG_COS_SINGLE: step_c1 = sv;
        REG_SIN_SINGLE: step_s1 = sv;
        REG_COS_VECTOR: step_cv = sv;
        REG_SIN_VECTOR: step_sv = sv;
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
    endfunction

    function longint rshift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function void turn(longint c, longint s, longint rc, longint rs,
                       output longint oc, output longint os);
      oc = clip(rshift(c * rc - s * rs, 22));
      os = clip(rshift(c * rs + s * rc, 22));
    endfunction

    function void rebuild(longint c0, longint s0);
      lc[0] = c0;
      ls[0] = s0;
      for (int k = 1; k < LANES; k++)
        turn(lc[k-1], ls[k-1], step_c1, step_s1, lc[k], ls[k]);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint scale_down(longint x, longint unsigned n);
      longint unsigned mag, q;
      mag = longint'(x < 0 ? -x : x) << 22;
      q = (mag + n / 2) / n;
      if (q > 64'd8388608) q = 64'd8388608;
      return clip(x < 0 ? -longint'(q) : longint'(q));
    endfunction

    function out_item_t snapshot();
      out_item_t o;
      o.cos_lane0 = lc[0][23:0];
      o.cos_lane1 = lc[1][23:0];
      o.cos_lane2 = lc[2][23:0];
      o.cos_lane3 = lc[3][23:0];
      o.sin_lane0 = ls[0][23:0];
      o.sin_lane1 = ls[1][23:0];
      o.sin_lane2 = ls[2][23:0];
      o.sin_lane3 = ls[3][23:0];
      return o;
    endfunction

    function void note_input(in_item_t it);
      out_item_t o;
      longint c, s, r2, ni;
      longint unsigned n;
      o = snapshot();
      case (it.op)
        OP_ADVANCE:
          for (int k = 0; k < LANES; k++) begin
            c = lc[k];
            s = ls[k];
            turn(c, s, step_cv, step_sv, lc[k], ls[k]);
          end
        OP_LOAD: rebuild(longint'(it.phase_cos), longint'(it.phase_sin));
        OP_RESYNC: rebuild(lc[0], ls[0]);
        OP_NORM:
          for (int k = 0; k < LANES; k++) begin
            c = lc[k];
            s = ls[k];
            n = root(longint'(c * c + s * s));
            if (n != 0) begin
              lc[k] = scale_down(c, n);
              ls[k] = scale_down(s, n);
            end
          end
        OP_FNORM:
          for (int k = 0; k < LANES; k++) begin
            c = lc[k];
            s = ls[k];
            r2 = c * c + s * s;
            ni = rshift((longint'(3) <<< 44) - r2, 23);
            lc[k] = clip(rshift(c * ni, 22));
            ls[k] = clip(rshift(s * ni, 22));
          end
        default: ;
      endcase
      if (it.op != OP_ADVANCE) o = snapshot();
      pending.push_back(o);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      logic [23:0] g, w;
      if (pending.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 8; i++) begin
        g = got[191 - 24*i -: 24];
        w = want[191 - 24*i -: 24];
        if (g !== w)
          report($sformatf("%s_lane%0d got %0d want %0d", i < 4 ? "cos" : "sin",
                           i % 4, signed'(g), signed'(w)));
      end
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;

  osc_scoreboard sb;
  int tx_idle, rx_idle, hold_cycles, quiet;

  quadrature_rotation_oscillator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle = 0;
    rx_idle = 0;
    hold_cycles = 0;
    quiet = 0;
    sb = new();
  end

  always #6 clk = ~clk;

  // receiver side
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= IDLE_LIMIT) begin
        $display("quadrature_rotation_oscillator_tb: errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic send(in_item_t it);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(logic [2:0] op, logic [23:0] pc, logic [23:0] ps);
    in_item_t it;
    it.op = op;
    it.phase_cos = pc;
    it.phase_sin = ps;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic logic [23:0] to_q(real x);
    real y;
    y = x * 4194304.0;
    y = y < 0 ? y - 0.5 : y + 0.5;
    if (y > 8388607.0) y = 8388607.0;
    return 24'($rtoi(y));
  endfunction

  task automatic set_angle(real th);
    write_reg(REG_COS_SINGLE, to_q($cos(th)));
    write_reg(REG_SIN_SINGLE, to_q($sin(th)));
    write_reg(REG_COS_VECTOR, to_q($cos(4.0 * th)));
    write_reg(REG_SIN_VECTOR, to_q($sin(4.0 * th)));
  endtask

  task automatic random_items(int count);
    int r;
    real a;
    logic [23:0] pc, ps;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      pc = 24'($urandom);
      ps = 24'($urandom);
      if (r < 50) send_op(OP_ADVANCE, pc, ps);
      else if (r < 65) begin
        if ($urandom_range(1)) begin
          a = $urandom_range(62831) / 10000.0;
          pc = to_q($cos(a));
          ps = to_q($sin(a));
        end
        send_op(OP_LOAD, pc, ps);
      end
      else if (r < 75) send_op(OP_RESYNC, pc, ps);
      else if (r < 85) send_op(OP_NORM, pc, ps);
      else if (r < 95) send_op(OP_FNORM, pc, ps);
      else send_op(3'($urandom_range(7, 5)), pc, ps);
    end
  endtask

  initial begin
    #1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset steps, extremes, every op but resync
    send_op(OP_ADVANCE, 24'h000000, 24'h000000);
    send_op(OP_LOAD, 24'h7fffff, 24'h800000);
    send_op(OP_ADVANCE, 24'hffffff, 24'hffffff);
    send_op(OP_NORM, 24'h0, 24'h0);
    send_op(OP_LOAD, 24'h800000, 24'h7fffff);
    send_op(OP_FNORM, 24'h0, 24'h0);
    send_op(OP_LOAD, 24'h000000, 24'h000000);
    send_op(OP_NORM, 24'h0, 24'h0);
    send_op(OP_FNORM, 24'h0, 24'h0);
    send_op(OP_LOAD, 24'h000001, 24'hffffff);
    send_op(OP_NORM, 24'h0, 24'h0);
    send_op(3'd5, 24'h555555, 24'haaaaaa);
    send_op(3'd6, 24'haaaaaa, 24'h555555);
    send_op(3'd7, 24'h0, 24'h0);
    drain();

    write_reg(REG_COS_SINGLE, 24'h7fffff);
    write_reg(REG_SIN_SINGLE, 24'h800000);
    write_reg(REG_COS_VECTOR, 24'h800000);
    write_reg(REG_SIN_VECTOR, 24'h7fffff);
    send_op(OP_LOAD, 24'h400000, 24'h000000);
    send_op(OP_ADVANCE, 24'h0, 24'h0);
    send_op(OP_ADVANCE, 24'h0, 24'h0);
    send_op(OP_RESYNC, 24'h0, 24'h0);
    send_op(OP_FNORM, 24'h0, 24'h0);
    send_op(OP_NORM, 24'h0, 24'h0);
    send_op(OP_ADVANCE, 24'h0, 24'h0);
    drain();

    for (int p = 0; p < 3; p++) begin
      tx_idle = (p == 0) ? 33 : (p == 1) ? 82 : 0;
      rx_idle = (p == 0) ? 82 : (p == 1) ? 33 : 0;
      set_angle($urandom_range(62831) / 10000.0);
      if (p == 2) hold_cycles = 400;
      random_items(150);
      drain();
      // full-range random register values
      write_reg(REG_COS_SINGLE, 24'($urandom));
      write_reg(REG_SIN_SINGLE, 24'($urandom));
      write_reg(REG_COS_VECTOR, 24'($urandom));
      write_reg(REG_SIN_VECTOR, 24'($urandom));
      random_items(150);
      drain();
    end

    if (sb.errors == 0)
      $display("quadrature_rotation_oscillator_tb: clean");
    else
      $display("quadrature_rotation_oscillator_tb: errors");
    $finish;
  end

endmodule
